// File: rtl/tste_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tste_pkg: shared types for the two-set table engine
// Command codes and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package tste_pkg;

    localparam logic [3:0] CMD_ADD_A  = 4'd0;
    localparam logic [3:0] CMD_ADD_B  = 4'd1;
    localparam logic [3:0] CMD_REM_A  = 4'd2;
    localparam logic [3:0] CMD_REM_B  = 4'd3;
    localparam logic [3:0] CMD_MEMBER = 4'd4;
    localparam logic [3:0] CMD_REL    = 4'd5;
    localparam logic [3:0] CMD_ISECT  = 4'd6;
    localparam logic [3:0] CMD_UNION  = 4'd7;
    localparam logic [3:0] CMD_DIFF   = 4'd8;
    localparam logic [3:0] CMD_CLEAR  = 4'd9;

    localparam int MAX_RESULTS = 32;

    // datapath operation selects
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,    // latch request, clear flags
        OP_SCAN,    // one step of the current scan
        OP_EMIT,    // present result
        OP_COMMIT   // apply add/remove/clear
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       phase_b;   // union and relations: second pass over B
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;       // current scan pass finished
        logic emit_valid;      // scan step produced a stream element
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/tste_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tste_datapath: tables, fills and scan logic
// Entry tables in flip-flops; one outer entry compared against the whole
// other table per cycle while the controller scans. Stream elements are captured one ahead in a buffer.
// ----------------------------------------------------------------------------
module tste_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tste_pkg::dp_cmd_t    dcmd,
    input  wire logic [3:0]           command,
    input  wire logic signed [31:0]   value,
    output tste_pkg::dp_status_t      dstat,
    output logic                      ok,
    output logic signed [31:0]        element,
    output logic                      has_element,
    output logic [4:0]                count_a,
    output logic [4:0]                count_b,
    output logic                      in_a,
    output logic                      in_b,
    output logic                      disjoint,
    output logic                      a_within_b,
    output logic                      b_within_a,
    output logic                      equal
);
    import tste_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int LW = $clog2(2 * CAPACITY);

    logic [31:0]   ta_reg [CAPACITY];
    logic [31:0]   tb_reg [CAPACITY];
    logic [31:0]   ul_reg [2*CAPACITY];   // union list built so far
    logic [FW-1:0] fa_reg, fb_reg;
    logic [LW:0]   un_reg;
    logic [FW-1:0] idx_reg;
    logic [3:0]    cmd_reg;
    logic [31:0]   val_reg;
    logic [31:0]   buf_reg;                // stream element waiting to go out
    logic          f1_reg, f2_reg, f3_reg; // disj, ab, ba
    logic          hit_reg;                // add had room / remove found

    logic [31:0]   cur;
    logic          cur_in_a, cur_in_b, cur_in_u, v_in_a, v_in_b;
    logic [IW-1:0] pos_a, pos_b;
    logic          fa_full, fb_full;
    logic [FW-1:0] lim;

    always_comb
    begin
        cur      = dcmd.phase_b ? tb_reg[idx_reg[IW-1:0]] : ta_reg[idx_reg[IW-1:0]];
        cur_in_a = 1'b0;
        cur_in_b = 1'b0;
        cur_in_u = 1'b0;
        v_in_a   = 1'b0;
        v_in_b   = 1'b0;
        pos_a    = '0;
        pos_b    = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (FW'(i) < fa_reg)
            begin
                if (ta_reg[i] == cur) cur_in_a = 1'b1;
                if (ta_reg[i] == val_reg)
                begin
                    v_in_a = 1'b1;
                    pos_a  = IW'(i);
                end
            end
            if (FW'(i) < fb_reg)
            begin
                if (tb_reg[i] == cur) cur_in_b = 1'b1;
                if (tb_reg[i] == val_reg)
                begin
                    v_in_b = 1'b1;
                    pos_b  = IW'(i);
                end
            end
        end
        for (int j = 0; j < 2 * CAPACITY; j++)
            if ((LW+1)'(j) < un_reg && ul_reg[j] == cur) cur_in_u = 1'b1;
        lim      = dcmd.phase_b ? fb_reg : fa_reg;
        fa_full  = (fa_reg >= FW'(CAPACITY));
        fb_full  = (fb_reg >= FW'(CAPACITY));
    end

    always_comb
    begin
        dstat.scan_done  = (idx_reg >= lim);
        dstat.emit_valid = 1'b0;
        if (idx_reg < lim)
        begin
            case (cmd_reg)
                CMD_ISECT: dstat.emit_valid = cur_in_b;
                CMD_DIFF:  dstat.emit_valid = !cur_in_b;
                CMD_UNION: dstat.emit_valid = dcmd.phase_b ? !cur_in_u : 1'b1;
                default:   dstat.emit_valid = 1'b0;
            endcase
        end
    end

    // fill fits the 5-bit count fields for capacities up to 31
    assign count_a = 5'(fa_reg);
    assign count_b = 5'(fb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_reg  <= '0;
            fb_reg  <= '0;
            idx_reg <= '0;
            un_reg  <= '0;
        end
        else
        begin
            case (dcmd.op)
                OP_LOAD:
                begin
                    cmd_reg <= command;
                    val_reg <= value;
                    idx_reg <= '0;
                    un_reg  <= '0;
                end
                OP_SCAN:
                begin
                    if (idx_reg < lim)
                    begin
                        if (dstat.emit_valid)
                            buf_reg <= cur;
                        if (dstat.emit_valid && cmd_reg == CMD_UNION)
                        begin
                            ul_reg[un_reg[LW-1:0]] <= cur;
                            un_reg <= un_reg + (LW+1)'(1);
                        end
                        idx_reg <= idx_reg + FW'(1);
                    end
                    else if ((cmd_reg == CMD_UNION || cmd_reg == CMD_REL) && !dcmd.phase_b)
                        idx_reg <= '0;
                end
                OP_COMMIT:
                begin
                    case (cmd_reg)
                        CMD_ADD_A: if (!fa_full)
                        begin
                            ta_reg[fa_reg[IW-1:0]] <= val_reg;
                            fa_reg <= fa_reg + FW'(1);
                        end
                        CMD_ADD_B: if (!fb_full)
                        begin
                            tb_reg[fb_reg[IW-1:0]] <= val_reg;
                            fb_reg <= fb_reg + FW'(1);
                        end
                        CMD_REM_A: if (v_in_a)
                        begin
                            for (int i = 0; i < CAPACITY - 1; i++)
                                if (IW'(i) >= pos_a) ta_reg[i] <= ta_reg[i+1];
                            fa_reg <= fa_reg - FW'(1);
                        end
                        CMD_REM_B: if (v_in_b)
                        begin
                            for (int i = 0; i < CAPACITY - 1; i++)
                                if (IW'(i) >= pos_b) tb_reg[i] <= tb_reg[i+1];
                            fb_reg <= fb_reg - FW'(1);
                        end
                        CMD_CLEAR:
                        begin
                            fa_reg <= '0;
                            fb_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // relation flags accumulate over the scan of A then B
    always_ff @(posedge clk)
    begin
        if (dcmd.op == OP_LOAD)
        begin
            f1_reg  <= 1'b1;
            f2_reg  <= 1'b1;
            f3_reg  <= 1'b1;
            hit_reg <= 1'b0;
        end
        else if (dcmd.op == OP_SCAN && idx_reg < lim && cmd_reg == CMD_REL)
        begin
            if (!dcmd.phase_b)
            begin
                if (cur_in_b) f1_reg <= 1'b0;
                else          f2_reg <= 1'b0;
            end
            else if (!cur_in_a)
                f3_reg <= 1'b0;
        end
        else if (dcmd.op == OP_COMMIT)
        begin
            hit_reg <= (cmd_reg == CMD_ADD_A) ? !fa_full :
                       (cmd_reg == CMD_ADD_B) ? !fb_full :
                       (cmd_reg == CMD_REM_A) ? v_in_a :
                       (cmd_reg == CMD_REM_B) ? v_in_b : 1'b0;
        end
    end

    // result fields from current state (valid while controller presents)
    always_comb
    begin
        ok          = 1'b0;
        element     = '0;
        has_element = 1'b0;
        in_a        = 1'b0;
        in_b        = 1'b0;
        disjoint    = 1'b0;
        a_within_b  = 1'b0;
        b_within_a  = 1'b0;
        equal       = 1'b0;
        case (cmd_reg)
            CMD_ADD_A, CMD_ADD_B, CMD_REM_A, CMD_REM_B: ok = hit_reg;
            CMD_CLEAR:  ok = 1'b1;
            CMD_MEMBER:
            begin
                in_a = v_in_a;
                in_b = v_in_b;
            end
            CMD_REL:
            begin
                disjoint   = f1_reg;
                a_within_b = f2_reg;
                b_within_a = f3_reg;
                equal      = f2_reg && (fa_reg == fb_reg);
            end
            CMD_ISECT, CMD_UNION, CMD_DIFF:
            begin
                has_element = (dcmd.op == OP_EMIT);
                element     = (dcmd.op == OP_EMIT) ? buf_reg : '0;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/tste_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tste_ctrl: request sequencer
// Steps the datapath scan, holds results until taken, applies updates.
// ----------------------------------------------------------------------------
module tste_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    output logic                    ready,
    input  wire logic [3:0]         command,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    last,
    output tste_pkg::dp_cmd_t       dcmd,
    input  wire tste_pkg::dp_status_t dstat
);
    import tste_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD,
        S_SINGLE,
        S_COMMIT
    } state_t;

    state_t     state_reg, state_next;
    logic       pb_reg, pb_next;
    logic [3:0] cmd_reg, cmd_next;
    logic [5:0] sent_reg, sent_next;
    logic       hb_reg, hb_next;      // datapath buffer holds an element
    logic       fin_reg, fin_next;    // buffered element is the final one
    logic       is_stream;

    assign is_stream = cmd_reg inside {CMD_ISECT, CMD_UNION, CMD_DIFF};
    assign ready     = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        pb_next    = pb_reg;
        cmd_next   = cmd_reg;
        sent_next  = sent_reg;
        hb_next    = hb_reg;
        fin_next   = fin_reg;
        dcmd.op    = OP_NONE;
        dcmd.phase_b = pb_reg;
        out_valid  = 1'b0;
        last       = 1'b0;
        case (state_reg)
            S_IDLE:
                if (valid)
                begin
                    dcmd.op    = OP_LOAD;
                    cmd_next   = command;
                    pb_next    = 1'b0;
                    sent_next  = '0;
                    hb_next    = 1'b0;
                    fin_next   = 1'b0;
                    if (command inside {CMD_REL, CMD_ISECT, CMD_UNION, CMD_DIFF})
                        state_next = S_SCAN;
                    else if (command inside {CMD_ADD_A, CMD_ADD_B, CMD_REM_A,
                                             CMD_REM_B, CMD_CLEAR})
                        state_next = S_COMMIT;
                    else
                        state_next = S_SINGLE;
                end
            S_SCAN:
            begin
                if (is_stream && dstat.emit_valid)
                begin
                    // one element kept back so the final one is known
                    if (hb_reg)
                        state_next = S_HOLD;
                    else
                    begin
                        dcmd.op = OP_SCAN;
                        hb_next = 1'b1;
                    end
                end
                else if (dstat.scan_done)
                begin
                    if ((cmd_reg == CMD_REL || cmd_reg == CMD_UNION) && !pb_reg)
                    begin
                        pb_next = 1'b1;
                        dcmd.op = OP_SCAN;
                    end
                    else if (hb_reg)
                    begin
                        fin_next   = 1'b1;
                        state_next = S_HOLD;
                    end
                    else
                        state_next = S_SINGLE;
                end
                else
                    dcmd.op = OP_SCAN;
            end
            S_HOLD:
            begin
                // buffered element stays presented until taken
                out_valid = 1'b1;
                dcmd.op   = OP_EMIT;
                last = fin_reg || (sent_reg == 6'(MAX_RESULTS - 1));
                if (out_ready)
                begin
                    sent_next  = sent_reg + 6'd1;
                    hb_next    = 1'b0;
                    state_next = last ? S_IDLE : S_SCAN;
                end
            end
            S_SINGLE:
            begin
                out_valid = 1'b1;
                last      = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            S_COMMIT:
            begin
                dcmd.op    = OP_COMMIT;
                state_next = S_SINGLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pb_reg    <= 1'b0;
            cmd_reg   <= '0;
            sent_reg  <= '0;
            hb_reg    <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pb_reg    <= pb_next;
            cmd_reg   <= cmd_next;
            sent_reg  <= sent_next;
            hb_reg    <= hb_next;
            fin_reg   <= fin_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/two_set_table_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_set_table_engine_core: two small integer sets with set operations
// Controller sequences scans over the entry tables held by the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: valid/ready with command and value. One request is taken
//   at a time; ready is high only while the engine is idle.
//   Result channel: out_valid/out_ready. Each request gives one result, or a
//   stream of elements for intersect, union and difference, the final item
//   flagged by last. An empty stream gives one item with has_element low.
//   Membership and unknown commands give their result directly; add, remove
//   and clear update first, then give the result.
//   Relations scan A then B, one entry a cycle.
//   Streams scan one outer entry a cycle against a full row of comparators
//   while no element waits to be handed off, and keep one element back so
//   the final one can carry last.
//   Stall: a result holds with its payload stable until out_ready; the scan
//   waits with it.
//   Reset: both fills go to zero; table contents stay undefined.
// ----------------------------------------------------------------------------
module two_set_table_engine_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    output logic                    ready,
    input  wire logic [3:0]         command,
    input  wire logic signed [31:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    ok,
    output logic signed [31:0]      element,
    output logic                    has_element,
    output logic                    last,
    output logic [4:0]              count_a,
    output logic [4:0]              count_b,
    output logic                    in_a,
    output logic                    in_b,
    output logic                    disjoint,
    output logic                    a_within_b,
    output logic                    b_within_a,
    output logic                    equal
);
    import tste_pkg::*;

    dp_cmd_t    dcmd;
    dp_status_t dstat;

    tste_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .ready     (ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .last      (last),
        .dcmd      (dcmd),
        .dstat     (dstat)
    );

    tste_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .dcmd        (dcmd),
        .command     (command),
        .value       (value),
        .dstat       (dstat),
        .ok          (ok),
        .element     (element),
        .has_element (has_element),
        .count_a     (count_a),
        .count_b     (count_b),
        .in_a        (in_a),
        .in_b        (in_b),
        .disjoint    (disjoint),
        .a_within_b  (a_within_b),
        .b_within_a  (b_within_a),
        .equal       (equal)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready && out_valid))
        else $error("request accepted while result pending");
    a_fill_a_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_a <= 5'(CAPACITY))
        else $error("fill A beyond capacity");
    a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_element |-> element == '0)
        else $error("element set without has_element");
`endif

endmodule
`default_nettype wire

// File: tb/two_set_table_engine_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_set_table_engine_core_tb: request/result check of the two-set engine
// Drives add, remove, membership, relations, stream and clear requests with
// random gaps and result stalls. A local model of both tables predicts every
// result item, and each item is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module two_set_table_engine_core_tb;
    import tste_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] element;
        logic               has_element;
        logic               last;
        logic [4:0]         count_a;
        logic [4:0]         count_b;
        logic               in_a;
        logic               in_b;
        logic               disjoint;
        logic               a_within_b;
        logic               b_within_a;
        logic               equal;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic valid = 1'b0;
    logic ready;
    logic [3:0] command = CMD_ADD_A;
    logic signed [31:0] value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    wire answer_t got;

    // model state: the two tables and their fills
    logic [31:0] tab_a [DEPTH];
    logic [31:0] tab_b [DEPTH];
    int unsigned fill_a = 0;
    int unsigned fill_b = 0;

    answer_t pending_answers[$];
    int errors = 0;
    bit stalls_on = 1'b1;
    int hold_cnt = 0;
    logic [31:0] pool [8];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    two_set_table_engine_core #(.CAPACITY(DEPTH)) u_top (
        .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
        .command(command), .value(value), .out_valid(out_valid),
        .out_ready(out_ready), .ok(got.ok), .element(got.element),
        .has_element(got.has_element), .last(got.last), .count_a(got.count_a),
        .count_b(got.count_b), .in_a(got.in_a), .in_b(got.in_b),
        .disjoint(got.disjoint), .a_within_b(got.a_within_b),
        .b_within_a(got.b_within_a), .equal(got.equal)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic answer_t base_answer();
        answer_t a;
        a = '0;
        a.count_a = fill_a[4:0];
        a.count_b = fill_b[4:0];
        return a;
    endfunction

    function automatic bit in_table(logic [31:0] t[], int unsigned n, logic [31:0] v);
        for (int i = 0; i < n; i++)
            if (t[i] == v) return 1'b1;
        return 1'b0;
    endfunction

    // Applies one request to the model tables and queues its result items.
    task automatic predict_request(logic [3:0] cmd, logic [31:0] v);
        answer_t a;
        logic [31:0] ta[], tb[], list[$];
        bit hit;
        ta = new[DEPTH];
        tb = new[DEPTH];
        foreach (ta[i]) ta[i] = tab_a[i];
        foreach (tb[i]) tb[i] = tab_b[i];
        hit = 1'b0;
        case (cmd)
            CMD_ADD_A:
            begin
                if (fill_a < DEPTH) begin tab_a[fill_a] = v; fill_a++; hit = 1'b1; end
            end
            CMD_ADD_B:
            begin
                if (fill_b < DEPTH) begin tab_b[fill_b] = v; fill_b++; hit = 1'b1; end
            end
            CMD_REM_A:
            begin
                for (int i = 0; i < fill_a && !hit; i++)
                    if (tab_a[i] == v)
                    begin
                        for (int j = i; j + 1 < fill_a; j++) tab_a[j] = tab_a[j + 1];
                        fill_a--;
                        hit = 1'b1;
                    end
            end
            CMD_REM_B:
            begin
                for (int i = 0; i < fill_b && !hit; i++)
                    if (tab_b[i] == v)
                    begin
                        for (int j = i; j + 1 < fill_b; j++) tab_b[j] = tab_b[j + 1];
                        fill_b--;
                        hit = 1'b1;
                    end
            end
            CMD_CLEAR:
            begin
                fill_a = 0; fill_b = 0; hit = 1'b1;
            end
            default: ;
        endcase
        a = base_answer();
        a.last = 1'b1;
        if (cmd <= CMD_REM_B || cmd == CMD_CLEAR)
            a.ok = hit;
        else if (cmd == CMD_MEMBER)
        begin
            a.in_a = in_table(ta, fill_a, v);
            a.in_b = in_table(tb, fill_b, v);
        end
        else if (cmd == CMD_REL)
        begin
            a.disjoint = 1'b1;
            a.a_within_b = 1'b1;
            a.b_within_a = 1'b1;
            for (int i = 0; i < fill_a; i++)
            begin
                if (in_table(tb, fill_b, ta[i])) a.disjoint = 1'b0;
                else a.a_within_b = 1'b0;
            end
            for (int i = 0; i < fill_b; i++)
                if (!in_table(ta, fill_a, tb[i])) a.b_within_a = 1'b0;
            a.equal = (fill_a == fill_b) && a.a_within_b;
        end
        if (cmd >= CMD_ISECT && cmd <= CMD_DIFF)
        begin
            for (int i = 0; i < fill_a; i++)
                if (cmd == CMD_UNION ||
                    in_table(tb, fill_b, ta[i]) == (cmd == CMD_ISECT))
                    list.push_back(ta[i]);
            if (cmd == CMD_UNION)
                for (int i = 0; i < fill_b; i++)
                begin
                    hit = 1'b0;
                    foreach (list[k]) if (list[k] == tb[i]) hit = 1'b1;
                    if (!hit) list.push_back(tb[i]);
                end
            while (list.size() > MAX_RESULTS) void'(list.pop_back());
            foreach (list[k])
            begin
                a = base_answer();
                a.element = list[k];
                a.has_element = 1'b1;
                a.last = (k == list.size() - 1);
                pending_answers.push_back(a);
            end
            if (list.size() == 0)
            begin
                a = base_answer();
                a.last = 1'b1;
                pending_answers.push_back(a);
            end
        end
        else
            pending_answers.push_back(a);
    endtask

    // Sends one request after a random gap and holds it until taken.
    task automatic send_request(logic [3:0] cmd, logic [31:0] v);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        command <= cmd;
        value <= v;
        valid <= 1'b1;
        do @(posedge clk); while (!ready);
        predict_request(cmd, v);
    endtask

    task automatic wait_drained();
        valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (2 * DEPTH + 10) @(posedge clk);
    endtask

    // result side: random stalls on out_ready, check on each accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("unexpected result item");
                    errors++;
                end
                else
                begin
                    answer_t e;
                    e = pending_answers.pop_front();
                    if (got.ok !== e.ok) begin $error("ok exp %0d got %0d", e.ok, got.ok); errors++; end
                    if (got.element !== e.element) begin $error("element exp %0d got %0d", e.element, got.element); errors++; end
                    if (got.has_element !== e.has_element) begin $error("has_element exp %0d got %0d", e.has_element, got.has_element); errors++; end
                    if (got.last !== e.last) begin $error("last exp %0d got %0d", e.last, got.last); errors++; end
                    if (got.count_a !== e.count_a) begin $error("count_a exp %0d got %0d", e.count_a, got.count_a); errors++; end
                    if (got.count_b !== e.count_b) begin $error("count_b exp %0d got %0d", e.count_b, got.count_b); errors++; end
                    if (got.in_a !== e.in_a) begin $error("in_a exp %0d got %0d", e.in_a, got.in_a); errors++; end
                    if (got.in_b !== e.in_b) begin $error("in_b exp %0d got %0d", e.in_b, got.in_b); errors++; end
                    if (got.disjoint !== e.disjoint) begin $error("disjoint exp %0d got %0d", e.disjoint, got.disjoint); errors++; end
                    if (got.a_within_b !== e.a_within_b) begin $error("a_within_b exp %0d got %0d", e.a_within_b, got.a_within_b); errors++; end
                    if (got.b_within_a !== e.b_within_a) begin $error("b_within_a exp %0d got %0d", e.b_within_a, got.b_within_a); errors++; end
                    if (got.equal !== e.equal) begin $error("equal exp %0d got %0d", e.equal, got.equal); errors++; end
                end
            end
            if (!stalls_on)
                out_ready <= 1'b1;
            else if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 9) < 6)
                out_ready <= 1'b1;
            else
            begin
                hold_cnt = gap_len();
                out_ready <= 1'b0;
            end
        end
    end

    // Extremes, every command, full tables, misses, empty and long streams.
    task automatic test_directed();
        send_request(CMD_DIFF, 0);                 // empty stream
        send_request(CMD_REL, 0);                  // empty sets
        send_request(CMD_REM_A, 32'h8000_0000);    // miss on empty table
        send_request(CMD_ADD_A, 32'h8000_0000);
        send_request(CMD_ADD_A, 32'h7FFF_FFFF);
        send_request(CMD_ADD_B, 32'h7FFF_FFFF);
        send_request(CMD_ADD_B, 32'hFFFF_FFFF);
        send_request(CMD_MEMBER, 32'h7FFF_FFFF);
        send_request(CMD_ISECT, 0);
        send_request(CMD_UNION, 0);
        send_request(CMD_REM_B, 32'h7FFF_FFFF);
        send_request(CMD_REL, 0);
        send_request(4'd10, 0);
        send_request(4'd15, 32'h5555_5555);
        send_request(CMD_CLEAR, 0);
        // fill both tables past capacity with distinct values: long union
        for (int i = 0; i < DEPTH + 1; i++) send_request(CMD_ADD_A, i);
        for (int i = 0; i < DEPTH + 1; i++) send_request(CMD_ADD_B, 100 + i);
        send_request(CMD_UNION, 0);
        send_request(CMD_REM_A, 0);                // remove head, shift
        send_request(CMD_REL, 0);
        send_request(CMD_CLEAR, 0);
    endtask

    // Random commands over a small value pool so hits are frequent.
    task automatic test_random(int n);
        logic [31:0] v;
        logic [3:0] cmd;
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            v = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
            if (r < 22) cmd = CMD_ADD_A;
            else if (r < 44) cmd = CMD_ADD_B;
            else if (r < 52) cmd = CMD_REM_A;
            else if (r < 60) cmd = CMD_REM_B;
            else if (r < 68) cmd = CMD_MEMBER;
            else if (r < 75) cmd = CMD_REL;
            else if (r < 82) cmd = CMD_ISECT;
            else if (r < 89) cmd = CMD_UNION;
            else if (r < 96) cmd = CMD_DIFF;
            else if (r < 98) cmd = CMD_CLEAR;
            else cmd = 4'($urandom_range(10, 15));
            send_request(cmd, v);
            if (k == n / 2) wait_drained();        // sender holds off
        end
    endtask

    // Equal sets in a different order, then full-speed results.
    task automatic test_equal_sets();
        send_request(CMD_CLEAR, 0);
        for (int i = 0; i < 4; i++) send_request(CMD_ADD_A, pool[i]);
        for (int i = 3; i >= 0; i--) send_request(CMD_ADD_B, pool[i]);
        send_request(CMD_REL, 0);
        wait_drained();
        stalls_on = 1'b0;
        send_request(CMD_UNION, 0);
        send_request(CMD_ISECT, 0);
        wait_drained();
        stalls_on = 1'b1;
    endtask

    initial
    begin
        foreach (pool[i]) pool[i] = $urandom();
        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_equal_sets();
        test_random(215);
        wait_drained();
        if (errors == 0)
            $display("two_set_table_engine_core verification clean");
        else
            $display("two_set_table_engine_core verification failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("two_set_table_engine_core verification failed");
        $finish;
    end

endmodule
